@@ src/phil_pkg.sv @@
// Shared types, codes and sizes for the two-level perfect hash lookup.
// No dependencies; phil_front, phil_back, the top level and the checker import this package.
`timescale 1ns / 1ps

package phil_pkg;

  // default table sizes
  localparam int BUCKETS_DEF = 1024;
  localparam int SLOTS_DEF   = 4096;

  // field widths
  localparam int KEY_W    = 32;
  localparam int ADDR_W   = 12;
  localparam int WIDE_W   = 33;
  localparam int CNT_W    = 13;
  localparam int BCOUNT_W = 11;

  // stream and config port widths
  localparam int IN_TDATA_W  = 168;
  localparam int IN_TUSER_W  = 2;
  localparam int OUT_TDATA_W = 40;
  localparam int OUT_PAD_W   = OUT_TDATA_W - KEY_W - 1;
  localparam int CFG_IDX_W   = 2;

  // operation codes on in_tuser
  localparam logic [IN_TUSER_W-1:0] OP_BLOAD  = 2'd0;
  localparam logic [IN_TUSER_W-1:0] OP_SLOAD  = 2'd1;
  localparam logic [IN_TUSER_W-1:0] OP_LOOKUP = 2'd2;

  // config register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_PRIME  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FMULT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FADD   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_BCOUNT = 2'd3;

  // work kinds after classification
  typedef logic [1:0] phil_kind_t;
  localparam phil_kind_t K_NONE   = 2'd0;
  localparam phil_kind_t K_BLOAD  = 2'd1;
  localparam phil_kind_t K_SLOAD  = 2'd2;
  localparam phil_kind_t K_LOOKUP = 2'd3;

  // input queue depth
  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = 2;

  typedef struct packed {
    logic [WIDE_W-1:0]   prime;
    logic [WIDE_W-1:0]   first_mult;
    logic [WIDE_W-1:0]   first_add;
    logic [BCOUNT_W-1:0] bucket_count;
  } phil_cfg_t;

  typedef struct packed {
    phil_kind_t        kind;
    logic [ADDR_W-1:0] addr;
    logic [KEY_W-1:0]  key;
    logic [KEY_W-1:0]  value;
    logic [WIDE_W-1:0] mult;
    logic [WIDE_W-1:0] addend;
    logic [CNT_W-1:0]  start;
    logic [CNT_W-1:0]  slots;
  } phil_item_t;

  localparam int ITEM_W = $bits(phil_item_t);

  typedef struct packed {
    logic [WIDE_W-1:0] mult;
    logic [WIDE_W-1:0] addend;
    logic [CNT_W-1:0]  start;
    logic [CNT_W-1:0]  slots;
  } phil_bucket_t;

  typedef struct packed {
    logic [KEY_W-1:0] value;
    logic [KEY_W-1:0] key;
  } phil_slot_t;

  typedef struct packed {
    logic clearing;
  } phil_status_t;

endpackage

@@ src/phil_ram.sv @@
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
`timescale 1ns / 1ps

module phil_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // registered read, held while re is low
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ src/phil_mod.sv @@
// Pipelined remainder unit: dividend mod divisor, STEP dividend bits per stage.
// Uses nothing from the package; the payload rides along unchanged.
`timescale 1ns / 1ps

module phil_mod #(
  parameter int DW   = 65,
  parameter int VW   = 33,
  parameter int STEP = 1,
  parameter int PW   = 8
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          v_in,
  input  logic [DW-1:0] dvd,
  input  logic [VW-1:0] dvs,
  input  logic [PW-1:0] pl_in,
  output logic          v_out,
  output logic [VW-1:0] rem,
  output logic [PW-1:0] pl_out
);

  localparam int NST  = (DW + STEP - 1) / STEP;
  localparam int PADW = NST * STEP;

  logic [PADW-1:0] dvd_r [NST];
  logic [VW-1:0]   dvs_r [NST];
  logic [VW-1:0]   rem_r [NST];
  logic [PW-1:0]   pl_r  [NST];
  logic            v_r   [NST];

  genvar s;
  generate
    for (s = 0; s < NST; s++) begin : g_stage
      logic [PADW-1:0] dvd_i;
      logic [VW-1:0]   dvs_i;
      logic [VW-1:0]   rem_i;
      logic [PW-1:0]   pl_i;
      logic            v_i;
      logic [VW-1:0]   rem_nxt;

      if (s == 0) begin : g_first
        assign dvd_i = PADW'(dvd);
        assign dvs_i = dvs;
        assign rem_i = '0;
        assign pl_i  = pl_in;
        assign v_i   = v_in;
      end else begin : g_next
        assign dvd_i = dvd_r[s-1];
        assign dvs_i = dvs_r[s-1];
        assign rem_i = rem_r[s-1];
        assign pl_i  = pl_r[s-1];
        assign v_i   = v_r[s-1];
      end

      // shift in dividend bits msb first, one compare and subtract each
      always_comb begin : p_step
        logic [VW:0] acc;
        acc     = '0;
        rem_nxt = rem_i;
        for (int j = 0; j < STEP; j++) begin
          acc = {rem_nxt, dvd_i[PADW-1-s*STEP-j]};
          if (acc >= {1'b0, dvs_i}) begin
            acc = acc - {1'b0, dvs_i};
          end
          rem_nxt = acc[VW-1:0];
        end
      end

      // stage valid
      always_ff @(posedge clk) begin
        if (!rst_n) begin
          v_r[s] <= 1'b0;
        end else if (en) begin
          v_r[s] <= v_i;
        end
      end

      // stage payload
      always_ff @(posedge clk) begin
        if (en) begin
          dvd_r[s] <= dvd_i;
          dvs_r[s] <= dvs_i;
          rem_r[s] <= rem_nxt;
          pl_r[s]  <= pl_i;
        end
      end
    end
  endgenerate

  assign v_out  = v_r[NST-1];
  assign rem    = rem_r[NST-1];
  assign pl_out = pl_r[NST-1];

endmodule

@@ src/phil_front.sv @@
// Front end: config registers, input classification and the input queue.
// Depends on phil_pkg.
`timescale 1ns / 1ps

module phil_front #(
  parameter int BUCKETS = phil_pkg::BUCKETS_DEF,
  parameter int SLOTS   = phil_pkg::SLOTS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [phil_pkg::IN_TDATA_W-1:0] in_tdata,
  input  logic [phil_pkg::IN_TUSER_W-1:0] in_tuser,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [phil_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [phil_pkg::WIDE_W-1:0]    cfg_data,
  input  phil_pkg::phil_status_t         status,
  output phil_pkg::phil_cfg_t            cfg,
  output logic                           q_valid,
  output phil_pkg::phil_item_t           q_item,
  input  logic                           q_pop
);

  import phil_pkg::*;

  phil_cfg_t         cfg_r;
  phil_item_t        item;
  phil_item_t        q_mem_r [Q_DEPTH];
  logic [Q_AW-1:0]   wr_ptr_r;
  logic [Q_AW-1:0]   rd_ptr_r;
  logic [Q_AW:0]     count_r;
  logic              push;

  // config writes are always taken
  assign cfg_ready = 1'b1;
  assign cfg       = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.prime        <= WIDE_W'(3);
      cfg_r.first_mult   <= WIDE_W'(1);
      cfg_r.first_add    <= '0;
      cfg_r.bucket_count <= BCOUNT_W'(1);
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_PRIME:  cfg_r.prime        <= cfg_data;
        CFG_FMULT:  cfg_r.first_mult   <= cfg_data;
        CFG_FADD:   cfg_r.first_add    <= cfg_data;
        CFG_BCOUNT: cfg_r.bucket_count <= cfg_data[BCOUNT_W-1:0];
      endcase
    end
  end

  // unpack and classify the incoming transaction
  always_comb begin
    item.key    = in_tdata[31:0];
    item.value  = in_tdata[63:32];
    item.addr   = in_tdata[75:64];
    item.mult   = in_tdata[108:76];
    item.addend = in_tdata[141:109];
    item.start  = in_tdata[154:142];
    item.slots  = in_tdata[167:155];
    unique case (in_tuser)
      OP_BLOAD:
        item.kind = (32'(item.addr) < 32'(BUCKETS)) ? K_BLOAD : K_NONE;
      OP_SLOAD:
        item.kind = (32'(item.addr) < 32'(SLOTS)) ? K_SLOAD : K_NONE;
      OP_LOOKUP:
        item.kind = (!item.key[KEY_W-1] && (cfg_r.prime != '0) &&
                     (cfg_r.bucket_count != '0)) ? K_LOOKUP : K_NONE;
      default:
        item.kind = K_NONE;
    endcase
  end

  // input queue
  assign in_tready = (count_r != (Q_AW+1)'(Q_DEPTH)) && !status.clearing;
  assign push      = in_tvalid && in_tready;
  assign q_valid   = (count_r != '0);
  assign q_item    = q_mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_ptr_r] <= item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (q_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (push && !q_pop) begin
        count_r <= count_r + 1'b1;
      end else if (!push && q_pop) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

@@ src/phil_back.sv @@
// Back end: hash pipelines, bucket and slot tables, output register.
// Depends on phil_pkg, phil_mod and phil_ram.
`timescale 1ns / 1ps

module phil_back #(
  parameter int BUCKETS = phil_pkg::BUCKETS_DEF,
  parameter int SLOTS   = phil_pkg::SLOTS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  phil_pkg::phil_cfg_t             cfg,
  input  logic                            q_valid,
  input  phil_pkg::phil_item_t            q_item,
  output logic                            q_pop,
  output phil_pkg::phil_status_t          status,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [phil_pkg::OUT_TDATA_W-1:0] out_tdata
);

  import phil_pkg::*;

  localparam int BIW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int SIW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  logic adv;

  // stage registers
  logic              v1_r, v2_r, v3_r, v4_r, v5_r, v6_r;
  phil_item_t        it1_r, it2_r, it3_r, it4_r, it5_r, it6_r;
  logic [63:0]       prod1_r, prod2_r;
  logic [64:0]       sum1_r, sum2_r;
  phil_item_t        it4_nxt, it6_nxt, it3_nxt;

  // modulo pipeline outputs
  logic              vp1, vb, vp2, vs;
  logic [WIDE_W-1:0] rem1, rem2;
  logic [BCOUNT_W-1:0] h;
  logic [CNT_W-1:0]  off;
  phil_item_t        itp1, itb, itp2, its;

  // tables
  logic              clr_r;
  logic [BIW-1:0]    clr_cnt_r;
  logic              b_we;
  logic [BIW-1:0]    b_waddr;
  phil_bucket_t      b_wdata, brd;
  logic [BIW+BCOUNT_W-1:0] h_wide;
  logic [BIW+ADDR_W-1:0]   ba_wide;
  logic [SIW+CNT_W:0]      sa_wide;
  logic [SIW+ADDR_W-1:0]   sw_wide;
  logic [CNT_W:0]    saddr;
  phil_slot_t        s_wdata, srd;

  // output register
  logic              out_valid_r;
  logic              out_found_r;
  logic [KEY_W-1:0]  out_index_r;
  logic              found;

  assign adv   = !out_valid_r || out_tready;
  assign q_pop = adv && q_valid;

  // control valids
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
    end else if (adv) begin
      v1_r <= q_valid;
      v2_r <= v1_r;
      v3_r <= vb;
      v4_r <= v3_r;
      v5_r <= v4_r;
      v6_r <= vs;
    end
  end

  // first level multiply and add
  always_ff @(posedge clk) begin
    if (adv) begin
      it1_r   <= q_item;
      prod1_r <= {31'd0, cfg.first_mult} * {33'd0, q_item.key[KEY_W-2:0]};
      it2_r   <= it1_r;
      sum1_r  <= 65'(prod1_r) + 65'(cfg.first_add);
    end
  end

  phil_mod #(.DW(65), .VW(WIDE_W), .STEP(1), .PW(ITEM_W)) u_mod_p1 (
    .clk(clk), .rst_n(rst_n), .en(adv), .v_in(v2_r), .dvd(sum1_r),
    .dvs(cfg.prime), .pl_in(it2_r), .v_out(vp1), .rem(rem1), .pl_out(itp1)
  );

  phil_mod #(.DW(WIDE_W), .VW(BCOUNT_W), .STEP(4), .PW(ITEM_W)) u_mod_b (
    .clk(clk), .rst_n(rst_n), .en(adv), .v_in(vp1), .dvd(rem1),
    .dvs(cfg.bucket_count), .pl_in(itp1), .v_out(vb), .rem(h), .pl_out(itb)
  );

  // clearing pass over the bucket table after reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r     <= 1'b1;
      clr_cnt_r <= '0;
    end else if (clr_r) begin
      clr_cnt_r <= clr_cnt_r + 1'b1;
      if (clr_cnt_r == BIW'(BUCKETS - 1)) begin
        clr_r <= 1'b0;
      end
    end
  end

  assign status.clearing = clr_r;

  // bucket table access: the clearing pass and loads write, lookups read
  assign h_wide  = (BIW+BCOUNT_W)'(h);
  assign ba_wide = (BIW+ADDR_W)'(itb.addr);
  assign b_we    = clr_r || (adv && vb && (itb.kind == K_BLOAD));
  assign b_waddr = clr_r ? clr_cnt_r : ba_wide[BIW-1:0];

  always_comb begin
    if (clr_r) begin
      b_wdata = '0;
    end else begin
      b_wdata.mult   = itb.mult;
      b_wdata.addend = itb.addend;
      b_wdata.start  = itb.start;
      b_wdata.slots  = itb.slots;
    end
    it3_nxt = itb;
    if ((itb.kind == K_LOOKUP) && !(32'(h) < 32'(BUCKETS))) begin
      it3_nxt.kind = K_NONE;
    end
  end

  phil_ram #(.WIDTH($bits(phil_bucket_t)), .DEPTH(BUCKETS)) u_bucket_ram (
    .clk(clk), .we(b_we), .waddr(b_waddr), .wdata(b_wdata),
    .re(adv), .raddr(h_wide[BIW-1:0]), .rdata(brd)
  );

  // merge bucket parameters, second level multiply and add
  always_comb begin
    it4_nxt        = it3_r;
    it4_nxt.addend = brd.addend;
    it4_nxt.start  = brd.start;
    it4_nxt.slots  = brd.slots;
    if ((it3_r.kind == K_LOOKUP) && (brd.slots == '0)) begin
      it4_nxt.kind = K_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      it3_r   <= it3_nxt;
      it4_r   <= it4_nxt;
      prod2_r <= {31'd0, brd.mult} * {33'd0, it3_r.key[KEY_W-2:0]};
      it5_r   <= it4_r;
      sum2_r  <= 65'(prod2_r) + 65'(it4_r.addend);
    end
  end

  phil_mod #(.DW(65), .VW(WIDE_W), .STEP(1), .PW(ITEM_W)) u_mod_p2 (
    .clk(clk), .rst_n(rst_n), .en(adv), .v_in(v5_r), .dvd(sum2_r),
    .dvs(cfg.prime), .pl_in(it5_r), .v_out(vp2), .rem(rem2), .pl_out(itp2)
  );

  phil_mod #(.DW(WIDE_W), .VW(CNT_W), .STEP(4), .PW(ITEM_W)) u_mod_s (
    .clk(clk), .rst_n(rst_n), .en(adv), .v_in(vp2), .dvd(rem2),
    .dvs(itp2.slots), .pl_in(itp2), .v_out(vs), .rem(off), .pl_out(its)
  );

  // slot table access
  assign saddr   = (CNT_W+1)'(its.start) + (CNT_W+1)'(off);
  assign sa_wide = (SIW+CNT_W+1)'(saddr);
  assign sw_wide = (SIW+ADDR_W)'(its.addr);
  assign s_wdata.value = its.value;
  assign s_wdata.key   = its.key;

  always_comb begin
    it6_nxt = its;
    if ((its.kind == K_LOOKUP) && !(32'(saddr) < 32'(SLOTS))) begin
      it6_nxt.kind = K_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      it6_r <= it6_nxt;
    end
  end

  phil_ram #(.WIDTH($bits(phil_slot_t)), .DEPTH(SLOTS)) u_slot_ram (
    .clk(clk), .we(adv && vs && (its.kind == K_SLOAD)),
    .waddr(sw_wide[SIW-1:0]), .wdata(s_wdata),
    .re(adv), .raddr(sa_wide[SIW-1:0]), .rdata(srd)
  );

  // key compare and output register
  assign found = (it6_r.kind == K_LOOKUP) && (srd.key == it6_r.key);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= v6_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_found_r <= found;
      out_index_r <= found ? srd.value : '1;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {OUT_PAD_W'(0), out_index_r, out_found_r};

endmodule

@@ src/perfect_hash_index_lookup.sv @@
// Top level of the two-level perfect hash index lookup.
// Depends on phil_pkg, phil_front, phil_back (and through it phil_mod, phil_ram).
//
// Usage:
//   in_*   : one transaction per operation; in_tuser carries the op code
//            (bucket load, slot load, lookup), in_tdata the operands.
//   out_*  : exactly one result transaction per input transaction, in order;
//            found plus the local index, or -1 when not found and for loads.
//   cfg_*  : register writes (prime, first multiplier, first addend,
//            bucket count), taken every cycle; write only while idle.
// Throughput is one transaction per cycle while the output is not stalled.
// The latency from the input handshake to out_tvalid is set by the two
// bit-serial mod-p pipelines (65 stages each) and the two narrow remainder pipelines (9 stages each).
// After reset the bucket table is cleared one entry per cycle, with
// in_tready low; config writes are accepted meanwhile.
// When out_tready is low with a result pending the whole back pipeline holds; a four-entry input
// queue keeps in_tready high until it fills.
`timescale 1ns / 1ps

module perfect_hash_index_lookup #(
  parameter int BUCKETS = phil_pkg::BUCKETS_DEF,
  parameter int SLOTS   = phil_pkg::SLOTS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // key [31:0], value [63:32], addr [75:64], mult [108:76],
  // addend [141:109], start_req [154:142], slots [167:155]
  input  logic [phil_pkg::IN_TDATA_W-1:0]  in_tdata,
  // op [1:0]
  input  logic [phil_pkg::IN_TUSER_W-1:0]  in_tuser,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // found [0], match_index [32:1], zero pad [39:33]
  output logic [phil_pkg::OUT_TDATA_W-1:0] out_tdata,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [phil_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [phil_pkg::WIDE_W-1:0]      cfg_data
);

  import phil_pkg::*;

  phil_cfg_t    cfg;
  phil_status_t status;
  phil_item_t   q_item;
  logic         q_valid;
  logic         q_pop;

  // classify and queue
  phil_front #(.BUCKETS(BUCKETS), .SLOTS(SLOTS)) u_front (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_tdata(in_tdata), .in_tuser(in_tuser),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data),
    .status(status), .cfg(cfg),
    .q_valid(q_valid), .q_item(q_item), .q_pop(q_pop)
  );

  // hash and table access
  phil_back #(.BUCKETS(BUCKETS), .SLOTS(SLOTS)) u_back (
    .clk(clk), .rst_n(rst_n), .cfg(cfg),
    .q_valid(q_valid), .q_item(q_item), .q_pop(q_pop),
    .status(status),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

endmodule

@@ src/phil_checker.sv @@
// Port-level checks for the perfect hash lookup, bound to the top level.
// Depends on phil_pkg and perfect_hash_index_lookup.
`timescale 1ns / 1ps

module phil_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_tready,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [phil_pkg::OUT_TDATA_W-1:0] out_tdata
);

  import phil_pkg::*;

  // a stalled result transaction holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // a miss always reports local index -1
  a_miss_index: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[0] |-> out_tdata[KEY_W:1] == '1)
    else $error("miss without index -1");

  // the table clear blocks input right after reset
  a_clear_block: assert property (@(posedge clk)
    !rst_n |=> !in_tready)
    else $error("input taken during table clear");

endmodule

bind perfect_hash_index_lookup phil_checker u_phil_checker (
  .clk(clk), .rst_n(rst_n), .in_tready(in_tready),
  .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
);
